/* rtl/core/cts_pkg.sv */
package cts_pkg;

  localparam int KEY_BITS   = 9;
  localparam int COORD_DROP = 3;
  localparam int REF_W      = 8;
  localparam int AGE_W      = 16;
  localparam int META_W     = AGE_W + 2;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_FILL   = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic calc1;
    logic calc2;
    logic calc3;
    logic scan;
    logic tick;
    logic clear;
    logic fill;
    logic post;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic sweep_done;
    logic want_fill;
    logic rsp_busy;
  } sts_t;

  // floor(log2(n)), elaboration only
  function automatic int flog2(input int n);
    int k;
    k = 0;
    for (int i = 1; i < 31; i++) begin
      if (n >= (1 << i)) k = i;
    end
    return k;
  endfunction

endpackage

/* rtl/core/cts_ram.sv */
module cts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/cts_ctrl.sv */
module cts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  logic [1:0]    cmd,
  input  cts_pkg::sts_t sts,
  output cts_pkg::ctl_t ctl
);
  import cts_pkg::*;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CALC1 = 4'd2;
  localparam logic [3:0] S_CALC2 = 4'd3;
  localparam logic [3:0] S_CALC3 = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_FILL  = 4'd6;
  localparam logic [3:0] S_TICK  = 4'd7;
  localparam logic [3:0] S_POST  = 4'd8;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl        = '0;
    state_next = state;
    req_stall  = (state != S_IDLE);
    case (state)
      S_CLR: begin
        if (sts.sweep_done) state_next = S_IDLE;
        else ctl.clear = 1'b1;
      end
      S_IDLE: begin
        if (req_valid) begin
          ctl.load = 1'b1;
          case (cmd)
            CMD_LOOKUP, CMD_FILL: state_next = S_CALC1;
            CMD_TICK:             state_next = S_TICK;
            default:              state_next = S_POST;
          endcase
        end
      end
      S_CALC1: begin
        ctl.calc1  = 1'b1;
        state_next = S_CALC2;
      end
      S_CALC2: begin
        ctl.calc2  = 1'b1;
        state_next = S_CALC3;
      end
      S_CALC3: begin
        ctl.calc3  = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) state_next = sts.want_fill ? S_FILL : S_POST;
        else ctl.scan = 1'b1;
      end
      S_FILL: begin
        ctl.fill   = 1'b1;
        state_next = S_POST;
      end
      S_TICK: begin
        if (sts.sweep_done) state_next = S_POST;
        else ctl.tick = 1'b1;
      end
      S_POST: begin
        if (!sts.rsp_busy) begin
          ctl.post   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* rtl/core/cts_datapath.sv */
module cts_datapath #(
  parameter int BANKS_X = 2,
  parameter int BANKS_Y = 2,
  parameter int SETS_X  = 4,
  parameter int SETS_Y  = 4,
  parameter int WAYS_X  = 2,
  parameter int WAYS_Y  = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  cts_pkg::ctl_t ctl,
  output cts_pkg::sts_t sts,
  input  logic [1:0]    cmd,
  input  logic [7:0]    ref_idx,
  input  logic [11:0]   x_coord,
  input  logic [11:0]   y_coord,
  input  logic          rsp_stall,
  output logic          rsp_valid,
  output logic          hit,
  output logic          filled,
  output logic [5:0]    set_number,
  output logic [1:0]    way_number
);
  import cts_pkg::*;

  localparam int IBX0 = flog2(SETS_X);
  localparam int IBX  = IBX0 > KEY_BITS ? KEY_BITS : IBX0;
  localparam int BBX0 = flog2(BANKS_X);
  localparam int BBX  = BBX0 > KEY_BITS - IBX ? KEY_BITS - IBX : BBX0;
  localparam int TBX  = KEY_BITS - IBX - BBX;
  localparam int IBY0 = flog2(SETS_Y);
  localparam int IBY  = IBY0 > KEY_BITS ? KEY_BITS : IBY0;
  localparam int BBY0 = flog2(BANKS_Y);
  localparam int BBY  = BBY0 > KEY_BITS - IBY ? KEY_BITS - IBY : BBY0;
  localparam int TBY  = KEY_BITS - IBY - BBY;
  localparam int TWX  = REF_W + TBX;
  localparam int TWY  = REF_W + TBY;
  localparam int TW   = TWX + TWY;
  localparam int TFW  = REF_W + KEY_BITS;

  localparam int WPS     = WAYS_X * WAYS_Y;
  localparam int SETS    = BANKS_X * BANKS_Y * SETS_X * SETS_Y;
  localparam int ENTRIES = SETS * WPS;
  localparam int SETW    = SETS > 1 ? $clog2(SETS) : 1;
  localparam int EW      = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
  localparam int WIW     = WPS > 1 ? $clog2(WPS) : 1;
  localparam int CNW     = $clog2(ENTRIES + 1);

  localparam int MUL_BX = BANKS_Y * SETS_X * SETS_Y;
  localparam int MUL_BY = SETS_X * SETS_Y;
  localparam int MUL_IX = SETS_Y;

  logic [1:0]          cmd_r;
  logic [REF_W-1:0]    ref_r;
  logic [KEY_BITS-1:0] kx, ky;
  logic [KEY_BITS-1:0] bx, ix, by, iy;
  logic [TFW-1:0]      tfx, tfy;
  logic [TWX-1:0]      tag_x_r;
  logic [TWY-1:0]      tag_y_r;
  logic [SETW-1:0]     p_bx, p_by, p_ix, p_iy, set_r;
  logic [EW-1:0]       base_r, raddr, rd_addr, fill_addr;
  logic [CNW-1:0]      cnt, lim;
  logic                rd_pend;
  logic [WIW-1:0]      rd_way, way_r, victim;
  logic                hit_r, filled_r;
  logic [AGE_W-1:0]    best, age_n;
  logic [TW-1:0]       tag_rd;
  logic [META_W-1:0]   meta_rd, m_wdata;
  logic [EW-1:0]       m_waddr;
  logic                m_we, match;

  // address split of the captured keys
  assign bx  = kx & KEY_BITS'((1 << BBX) - 1);
  assign ix  = (kx >> BBX) & KEY_BITS'((1 << IBX) - 1);
  assign by  = ky & KEY_BITS'((1 << BBY) - 1);
  assign iy  = (ky >> BBY) & KEY_BITS'((1 << IBY) - 1);
  assign tfx = (TFW'(ref_r) << TBX) | TFW'(kx >> (BBX + IBX));
  assign tfy = (TFW'(ref_r) << TBY) | TFW'(ky >> (BBY + IBY));

  assign lim       = ctl.tick ? CNW'(ENTRIES) : CNW'(WPS);
  assign raddr     = ctl.tick ? cnt[EW-1:0] : base_r + EW'(cnt);
  assign fill_addr = base_r + EW'(victim);

  assign match = rd_pend && meta_rd[META_W-1] && (tag_rd == {tag_x_r, tag_y_r});
  assign age_n = meta_rd[META_W-2] ? '0 :
                 (meta_rd[AGE_W-1:0] == AGE_MAX ? AGE_MAX : meta_rd[AGE_W-1:0] + 1'b1);

  always_comb begin
    m_we    = 1'b0;
    m_waddr = rd_addr;
    m_wdata = '0;
    if (ctl.clear) begin
      m_we    = 1'b1;
      m_waddr = cnt[EW-1:0];
    end else if (ctl.fill) begin
      m_we    = 1'b1;
      m_waddr = fill_addr;
      m_wdata = {1'b1, 1'b1, best};
    end else if (ctl.scan && match) begin
      m_we    = 1'b1;
      m_wdata = {meta_rd[META_W-1], 1'b1, meta_rd[AGE_W-1:0]};
    end else if (ctl.tick && rd_pend) begin
      m_we    = 1'b1;
      m_wdata = {meta_rd[META_W-1], 1'b0, age_n};
    end
  end

  cts_ram #(.WIDTH(TW), .DEPTH(ENTRIES)) u_tag_ram (
    .clk   (clk),
    .we    (ctl.fill),
    .waddr (fill_addr),
    .wdata ({tag_x_r, tag_y_r}),
    .raddr (raddr),
    .rdata (tag_rd)
  );

  cts_ram #(.WIDTH(META_W), .DEPTH(ENTRIES)) u_meta_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (raddr),
    .rdata (meta_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (ctl.load) begin
        cnt     <= '0;
        rd_pend <= 1'b0;
      end else if (ctl.scan || ctl.tick) begin
        if (cnt < lim) begin
          cnt     <= cnt + 1'b1;
          rd_pend <= 1'b1;
        end else begin
          rd_pend <= 1'b0;
        end
      end else if (ctl.clear) begin
        cnt <= cnt + 1'b1;
      end
      if (ctl.post) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr <= raddr;
    rd_way  <= cnt[WIW-1:0];
    if (ctl.load) begin
      cmd_r    <= cmd;
      ref_r    <= ref_idx;
      kx       <= x_coord[11:COORD_DROP];
      ky       <= y_coord[11:COORD_DROP];
      hit_r    <= 1'b0;
      filled_r <= 1'b0;
      way_r    <= '0;
      best     <= '0;
      victim   <= '0;
    end
    if (ctl.calc1) begin
      tag_x_r <= TWX'(tfx);
      tag_y_r <= TWY'(tfy);
      p_bx    <= SETW'(32'(bx) * 32'(MUL_BX));
      p_by    <= SETW'(32'(by) * 32'(MUL_BY));
      p_ix    <= SETW'(32'(ix) * 32'(MUL_IX));
      p_iy    <= SETW'(iy);
    end
    if (ctl.calc2) set_r <= p_bx + p_by + p_ix + p_iy;
    if (ctl.calc3) base_r <= EW'(32'(set_r) * 32'(WPS));
    if (ctl.scan && rd_pend) begin
      if (rd_way == '0 || meta_rd[AGE_W-1:0] >= best) begin
        best   <= meta_rd[AGE_W-1:0];
        victim <= rd_way;
      end
      if (match) begin
        hit_r <= 1'b1;
        if (!hit_r) way_r <= rd_way;
      end
    end
    if (ctl.fill) begin
      filled_r <= 1'b1;
      way_r    <= victim;
    end
    if (ctl.post) begin
      hit        <= hit_r;
      filled     <= filled_r;
      way_number <= 2'(way_r);
      set_number <= (cmd_r == CMD_LOOKUP || cmd_r == CMD_FILL) ? 6'(set_r) : 6'd0;
    end
  end

  assign sts.scan_done  = (cnt == CNW'(WPS)) && !rd_pend;
  assign sts.sweep_done = (cnt == CNW'(ENTRIES)) && !rd_pend;
  assign sts.want_fill  = !hit_r && (cmd_r == CMD_FILL);
  assign sts.rsp_busy   = rsp_valid && rsp_stall;

endmodule

/* rtl/core/two_axis_set_assoc_cache_tags.sv */
// Two-axis set-associative cache tag store with age-based replacement.
// Request channel: req_valid/req_stall with cmd, ref_idx, x_coord, y_coord.
//   cmd lookup or lookup+fill resolves one set of WAYS_X*WAYS_Y ways;
//   age tick zeroes touched entries, ages the rest, clears the marks.
// Response channel: rsp_valid/rsp_stall with hit, filled, set_number,
//   way_number; exactly one response per request, in order.
// Flow: one request at a time. A lookup scans the set's ways and an age
//   tick sweeps all entries = BANKS_X*BANKS_Y*SETS_X*SETS_Y*WAYS_X*WAYS_Y,
//   one entry per cycle through the read port of the tag/age memories.
//   Unused cmd codes answer with all zeros. The next request can be taken
//   in the cycle its predecessor's response appears.
// Reset: a clearing pass over all entries zeroes valid/age/mark state;
//   req_stall stays high until it ends. Tags are not cleared.
// Stall: the response register holds while rsp_stall is high; the next
//   request is taken and worked on meanwhile, and waits before posting.
module two_axis_set_assoc_cache_tags #(
  parameter int BANKS_X = 2,
  parameter int BANKS_Y = 2,
  parameter int SETS_X  = 4,
  parameter int SETS_Y  = 4,
  parameter int WAYS_X  = 2,
  parameter int WAYS_Y  = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  ref_idx,
  input  logic [11:0] x_coord,
  input  logic [11:0] y_coord,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        hit,
  output logic        filled,
  output logic [5:0]  set_number,
  output logic [1:0]  way_number
);
  import cts_pkg::*;

  ctl_t ctl;  // sequencer commands
  sts_t sts;  // datapath status

  cts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .sts       (sts),
    .ctl       (ctl)
  );

  cts_datapath #(
    .BANKS_X (BANKS_X),
    .BANKS_Y (BANKS_Y),
    .SETS_X  (SETS_X),
    .SETS_Y  (SETS_Y),
    .WAYS_X  (WAYS_X),
    .WAYS_Y  (WAYS_Y)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .cmd        (cmd),
    .ref_idx    (ref_idx),
    .x_coord    (x_coord),
    .y_coord    (y_coord),
    .rsp_stall  (rsp_stall),
    .rsp_valid  (rsp_valid),
    .hit        (hit),
    .filled     (filled),
    .set_number (set_number),
    .way_number (way_number)
  );

endmodule
